>>> sv/lpfr_pkg.sv
// Shared types and codes for the length-prefixed frame receiver.
package lpfr_pkg;

	// Size byte counts itself and the type byte
	localparam logic [7:0] SIZE_OVERHEAD = 8'd2;

	// Frame parser phases
	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_TYPE    = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_TRAILER = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_TYPE    = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       frame_ok;
		logic       last;
	} res_item_t;

	// Request from the parser into the output stage
	typedef struct packed {
		logic      push;
		res_item_t item;
	} res_push_t;

endpackage

>>> sv/lpfr_stream_if.sv
// Valid/ready stream interface carrying one payload item per request.
interface lpfr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/lpfr_parser.sv
// Frame parser: phase, byte counter and trailer check for each accepted byte.
module lpfr_parser
	import lpfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output res_push_t  res_push
);

	logic [1:0] phase_q;
	logic [7:0] bytes_left_q;
	logic [7:0] expected_trailer_q;

	logic [1:0] phase_d;
	logic [7:0] bytes_left_d;
	logic [7:0] expected_trailer_d;
	logic [7:0] left_dec;

	// Count down payload bytes, never below zero
	assign left_dec = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : bytes_left_q;

	// Decode the next phase and the result for this byte
	always_comb begin
		phase_d            = phase_q;
		bytes_left_d       = bytes_left_q;
		expected_trailer_d = expected_trailer_q;
		res_push           = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte >= SIZE_OVERHEAD) begin
					bytes_left_d       = rx_byte - SIZE_OVERHEAD;
					expected_trailer_d = ~rx_byte;
					phase_d            = PH_TYPE;
				end
			end
			PH_TYPE: begin
				phase_d            = (bytes_left_q == 8'd0) ? PH_TRAILER : PH_PAYLOAD;
				res_push.push      = 1'b1;
				res_push.item.kind = KIND_TYPE;
				res_push.item.data = rx_byte;
			end
			PH_PAYLOAD: begin
				bytes_left_d       = left_dec;
				if (left_dec == 8'd0) begin
					phase_d = PH_TRAILER;
				end
				res_push.push      = 1'b1;
				res_push.item.kind = KIND_PAYLOAD;
				res_push.item.data = rx_byte;
			end
			PH_TRAILER: begin
				phase_d                = PH_HUNT;
				bytes_left_d           = 8'd0;
				res_push.push          = 1'b1;
				res_push.item.kind     = KIND_END;
				res_push.item.frame_ok = (rx_byte == expected_trailer_q);
				res_push.item.last     = 1'b1;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		// Only an accepted request produces a result
		res_push.push = res_push.push & accept;
	end

	// Advance the frame state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q            <= PH_HUNT;
			bytes_left_q       <= 8'd0;
			expected_trailer_q <= 8'd0;
		end else if (accept) begin
			phase_q            <= phase_d;
			bytes_left_q       <= bytes_left_d;
			expected_trailer_q <= expected_trailer_d;
		end
	end

endmodule

>>> sv/lpfr_out_stage.sv
// Output register with a skid entry so the input side can still take one result on a stall.
module lpfr_out_stage
	import lpfr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  res_push_t res_push,
	output logic      space,
	output logic      out_valid,
	input  logic      out_ready,
	output res_item_t out_item
);

	logic      main_valid_q;
	logic      skid_valid_q;
	res_item_t main_q;
	res_item_t skid_q;
	logic      pop;

	assign pop       = main_valid_q & out_ready;
	assign space     = ~skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_item  = main_q;

	// Track occupancy of the main and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_push.push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	// Move payload into the main or skid entry
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (res_push.push) begin
			if (main_valid_q && !pop) begin
				skid_q <= res_push.item;
			end else begin
				main_q <= res_push.item;
			end
		end
	end

endmodule

>>> sv/length_prefixed_frame_receiver_top.sv
// Top level of the length-prefixed frame receiver.
//
// Usage:
//   rx  - sink channel, one received serial byte per request (rx_byte).
//   res - source channel, one result per request: kind (type byte, payload
//         byte, end of frame), data, frame_ok and last.
//   Bytes below two are dropped while hunting; a byte of two or more starts a frame.
//   The type byte and every payload byte leave as soon as they arrive, before
//   the trailer is checked. The end-of-frame result carries last and frame_ok,
//   and downstream drops the frame when frame_ok is low.
// Output: each result is registered in the output stage before res offers it.
// Throughput: one byte per cycle while res is not stalled; the frame state is
//   registered and a result register with one skid entry separates the two channels.
// Stall: while res is stalled, rx keeps taking bytes until one more result
//   lands in the skid entry; then rx.ready stays low until res takes a result.
// Reset: arst_n clears both entries and returns the parser to hunting.
module length_prefixed_frame_receiver_top
	import lpfr_pkg::*;
(
	input  logic                             clk,
	input  logic                             arst_n,
	lpfr_stream_if.sink                      rx,
	lpfr_stream_if.source                    res
);

	logic      accept;
	logic      space;
	res_push_t res_push;
	res_item_t out_item;
	rx_item_t  rx_item;

	assign rx_item  = rx.payload;
	assign rx.ready = space;
	assign accept   = rx.valid & space;

	// Parse the byte stream into frames
	lpfr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_item.rx_byte),
		.res_push (res_push)
	);

	// Hold results for the downstream side
	lpfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.space     (space),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_item  (out_item)
	);

	assign res.payload = out_item;

endmodule

>>> sv/lpfr_checker.sv
// Port-level checks for the frame receiver and their bind to the top level.
module lpfr_checker
	import lpfr_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res_item
);

	// Hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("stalled result changed");

	// Mark only the end-of-frame result as last
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.last == (res_item.kind == KIND_END)))
		else $error("last does not match end-of-frame kind");

	// Report frame_ok only on the end-of-frame result
	a_ok_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.last |-> !res_item.frame_ok)
		else $error("frame_ok set before end of frame");

	// Zero data on the end-of-frame result
	a_end_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.last |-> res_item.data == 8'd0)
		else $error("end-of-frame result carries data");

endmodule

bind length_prefixed_frame_receiver_top lpfr_checker u_lpfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_item  (res.payload)
);

>>> bench/tb_length_prefixed_frame_receiver_top.sv
// Self-checking testbench for the length-prefixed frame receiver top level.
module tb_length_prefixed_frame_receiver_top;
	import lpfr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_LIMIT = 10;
	localparam int SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;

	lpfr_stream_if #(.payload_t(rx_item_t))  rx_ch ();
	lpfr_stream_if #(.payload_t(res_item_t)) res_ch ();

	length_prefixed_frame_receiver_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	// Idle and stall odds, in percent
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	// Frame parser mirror
	logic [1:0] parse_phase;
	logic [7:0] payload_left;
	logic [7:0] trailer_want;

	res_item_t expected_results[$];

	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned results_checked;
	int unsigned bytes_taken;
	int unsigned frames_closed;
	int unsigned frames_bad;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Track one accepted byte through the frame parser; return 0 for dropped filler
	function automatic bit parse_rx_byte(input logic [7:0] b);
		res_item_t r;
		bit taken;
		taken = 1'b1;
		r = '0;
		case (parse_phase)
			PH_HUNT: begin
				if (b < SIZE_OVERHEAD) begin
					taken = 1'b0;
				end else begin
					payload_left = b - SIZE_OVERHEAD;
					trailer_want = ~b;
					parse_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				parse_phase = (payload_left == 8'd0) ? PH_TRAILER : PH_PAYLOAD;
				r.kind = KIND_TYPE;
				r.data = b;
				expected_results.push_back(r);
			end
			PH_PAYLOAD: begin
				if (payload_left != 8'd0)
					payload_left = payload_left - 8'd1;
				if (payload_left == 8'd0)
					parse_phase = PH_TRAILER;
				r.kind = KIND_PAYLOAD;
				r.data = b;
				expected_results.push_back(r);
			end
			default: begin
				r.kind = KIND_END;
				r.frame_ok = (b == trailer_want);
				r.last = 1'b1;
				expected_results.push_back(r);
				frames_closed++;
				if (!r.frame_ok)
					frames_bad++;
				parse_phase = PH_HUNT;
				payload_left = 8'd0;
			end
		endcase
		return taken;
	endfunction

	// Offer one byte, idling at random first; return at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.payload <= '{rx_byte: b};
		do
			@(posedge clk);
		while (!rx_ch.ready);
		if (parse_rx_byte(b))
			bytes_taken++;
		@(negedge clk);
	endtask

	// Send a whole frame with random payload; a bad trailer never matches by chance
	task automatic send_frame(input logic [7:0] size_byte, input logic [7:0] type_byte,
			input bit good_trailer);
		logic [7:0] bad;
		send_byte(size_byte);
		send_byte(type_byte);
		repeat (int'(size_byte - SIZE_OVERHEAD))
			send_byte(8'($urandom));
		bad = 8'($urandom);
		if (bad == ~size_byte)
			bad = bad ^ 8'h01;
		send_byte(good_trailer ? ~size_byte : bad);
	endtask

	// Hold the link quiet until every expected result has come
	task automatic wait_results_drained();
		rx_ch.valid <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Filler in the hunt, empty payloads with good and bad trailers
	task automatic test_filler_and_empty_frames();
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h02);
		send_byte(8'hFF);
		send_byte(8'hFD);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h00);
	endtask

	// Payload bytes at the extremes, including values that look like filler
	task automatic test_payload_extremes();
		send_byte(8'h05);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'hFA);
		send_byte(8'h03);
		send_byte(8'hA5);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'h01);
	endtask

	// Stop the sender mid-run until the block has drained
	task automatic test_drain_pause();
		send_byte(8'h04);
		send_byte(8'h3C);
		send_byte(8'h7E);
		wait_results_drained();
		send_byte(8'h81);
		send_byte(8'hFB);
	endtask

	// Largest size byte gives a 253-byte payload
	task automatic test_largest_frame();
		send_frame(8'hFF, 8'($urandom), 1'b1);
	endtask

	// Mostly well-formed frames with random content, some noise and bad trailers
	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned budget);
		int unsigned stop_at;
		int unsigned pick;
		logic [7:0] size_byte;
		stop_at = bytes_taken + budget;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (bytes_taken < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// noise burst of filler and arbitrary bytes
				repeat ($urandom_range(1, 5)) begin
					if ($urandom_range(0, 1))
						send_byte(8'($urandom_range(0, 1)));
					else
						send_byte(8'($urandom));
				end
			end else begin
				repeat ($urandom_range(0, 2))
					send_byte(8'($urandom_range(0, 1)));
				pick = $urandom_range(0, 99);
				if (pick < 70)
					size_byte = 8'($urandom_range(2, 6));
				else if (pick < 95)
					size_byte = 8'($urandom_range(7, 30));
				else
					size_byte = 8'($urandom_range(31, 80));
				send_frame(size_byte, 8'($urandom), $urandom_range(0, 99) < 75);
			end
		end
	endtask

	// Receiver stalls
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Compare each delivered result with the oldest expectation
	always @(posedge clk) begin : check_results
		res_item_t want;
		res_item_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.payload;
			results_checked++;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: kind %0d data %02h ok %0b last %0b",
						got.kind, got.data, got.frame_ok, got.last);
			end else begin
				want = expected_results.pop_front();
				if (got.kind !== want.kind || got.data !== want.data ||
						got.frame_ok !== want.frame_ok || got.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("mismatch at cycle %0d: exp kind %0d data %02h ok %0b last %0b,",
							cycle_count, want.kind, want.data, want.frame_ok, want.last,
							" got kind %0d data %02h ok %0b last %0b",
							got.kind, got.data, got.frame_ok, got.last);
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, expected_results.size());
			$display("status: fail");
			$finish;
		end
	end

	// Reset, run the tests, report
	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.payload = '0;
		res_ch.ready = 1'b0;
		send_idle_pct = 33;
		recv_stall_pct = 73;
		parse_phase = PH_HUNT;
		payload_left = 8'd0;
		trailer_want = 8'd0;
		cycle_count = 0;
		mismatch_count = 0;
		results_checked = 0;
		bytes_taken = 0;
		frames_closed = 0;
		frames_bad = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_filler_and_empty_frames();
		test_payload_extremes();
		test_drain_pause();
		test_largest_frame();
		test_random_traffic(33, 73, 180);
		test_random_traffic(73, 33, 180);
		test_random_traffic(0, 0, 180);

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d frame bytes in %0d frames (%0d with bad trailer),",
			bytes_taken, frames_closed, frames_bad, " %0d results checked",
			results_checked);
		$display("mismatches: %0d, cycles: %0d", mismatch_count, cycle_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
